/* rtl/y2r_pkg.sv */
// Shared types and chroma lookup tables for the YCbCr 4:2:0 to RGB565 converter.
// No dependencies; used by yuv420_to_rgb565_quad.
`default_nettype none

package y2r_pkg;

   // Input beat: one 2x2 block, four luma samples plus shared chroma.
   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_type;

   // Result beat: two RGB565 pixels per row, left pixel in the low half.
   typedef struct packed {
      logic [31:0] top_pair;
      logic [31:0] bottom_pair;
   } rsp_type;

   localparam int unsigned TabDepth = 256;
   localparam int          ChromaBias = 128;

   typedef logic signed [8:0] ub_tab_type [TabDepth];   // -226..225
   typedef logic signed [6:0] ug_tab_type [TabDepth];   // -44..43
   typedef logic signed [7:0] vg_tab_type [TabDepth];   // -91..90
   typedef logic signed [8:0] vr_tab_type [TabDepth];   // -179..178

   // Tables hold k*(c-128) truncated toward zero, built at elaboration.
   function automatic ub_tab_type build_ub();
      ub_tab_type t;
      for (int i = 0; i < TabDepth; i++) begin
         t[i] = 9'(((i - ChromaBias) * 1772) / 1000);
      end
      return t;
   endfunction

   function automatic ug_tab_type build_ug();
      ug_tab_type t;
      for (int i = 0; i < TabDepth; i++) begin
         t[i] = 7'(((i - ChromaBias) * 34414) / 100000);
      end
      return t;
   endfunction

   function automatic vg_tab_type build_vg();
      vg_tab_type t;
      for (int i = 0; i < TabDepth; i++) begin
         t[i] = 8'(((i - ChromaBias) * 71414) / 100000);
      end
      return t;
   endfunction

   function automatic vr_tab_type build_vr();
      vr_tab_type t;
      for (int i = 0; i < TabDepth; i++) begin
         t[i] = 9'(((i - ChromaBias) * 1402) / 1000);
      end
      return t;
   endfunction

   localparam ub_tab_type UbTab = build_ub();
   localparam ug_tab_type UgTab = build_ug();
   localparam vg_tab_type VgTab = build_vg();
   localparam vr_tab_type VrTab = build_vr();

endpackage

`default_nettype wire

/* rtl/y2r_pixel.sv */
// One pixel: adds chroma terms to luma, clamps each component to 0..255, packs RGB565.
// Purely combinational; no package dependencies.
`default_nettype none

module y2r_pixel (
   input  wire logic        [7:0]  luma,
   input  wire logic signed [8:0]  blue_term,
   input  wire logic signed [8:0]  green_term,   // ug + vg, subtracted
   input  wire logic signed [8:0]  red_term,
   output      logic        [15:0] pixel
);

   logic signed [10:0] luma_s;
   logic signed [10:0] b_sum;
   logic signed [10:0] g_sum;
   logic signed [10:0] r_sum;
   logic        [7:0]  b_sat;
   logic        [7:0]  g_sat;
   logic        [7:0]  r_sat;

   function automatic logic [7:0] sat8(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > 11'sd255) begin
         res = 8'hFF;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   always_comb begin
      luma_s = $signed({3'b000, luma});
      b_sum  = luma_s + {{2{blue_term[8]}}, blue_term};
      g_sum  = luma_s - {{2{green_term[8]}}, green_term};
      r_sum  = luma_s + {{2{red_term[8]}}, red_term};
      b_sat  = sat8(b_sum);
      g_sat  = sat8(g_sum);
      r_sat  = sat8(r_sum);
      pixel  = {r_sat[7:3], g_sat[7:2], b_sat[7:3]};
   end

endmodule

`default_nettype wire

/* rtl/yuv420_to_rgb565_quad.sv */
// Top level: YCbCr 4:2:0 2x2 block to two RGB565 pixel pairs.
// Depends on y2r_pkg (types, chroma tables) and y2r_pixel.
//
// Usage:
//   Input channel: drive req_data with one 2x2 block (four luma bytes and the
//   shared Cb/Cr bytes) and raise start. A beat is taken on every rising edge
//   with start high and busy low. busy is always low: a new block can be
//   issued every cycle.
//   Result channel: rsp_valid pulses for one cycle with rsp_data holding the
//   top and bottom pixel pairs (left pixel in bits 15:0 of each word).
//   From the accepting edge the block passes through one input register, then
//   table lookup, add, clamp and pack into the result register. Throughput is
//   one block per cycle.
//   The receiver cannot stall; each result is shown exactly once.
//   Reset clears the valid pipeline; blocks in flight are dropped.
//   The block holds no other state.
`default_nettype none

module yuv420_to_rgb565_quad (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire y2r_pkg::req_type req_data,
   output      logic             rsp_valid,
   output      y2r_pkg::rsp_type rsp_data
);

   y2r_pkg::req_type req_ff;
   y2r_pkg::req_type req_in;
   logic             stage_valid_ff;
   logic             stage_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   y2r_pkg::rsp_type rsp_ff;
   y2r_pkg::rsp_type rsp_in;

   logic signed [8:0] ub;
   logic signed [6:0] ug;
   logic signed [7:0] vg;
   logic signed [8:0] vr;
   logic signed [8:0] g_term;
   logic [15:0]       pix_tl;
   logic [15:0]       pix_tr;
   logic [15:0]       pix_bl;
   logic [15:0]       pix_br;

   assign busy = 1'b0;

   always_comb begin
      stage_valid_in = start & ~busy;
      req_in         = stage_valid_in ? req_data : req_ff;
   end

   always_comb begin
      ub     = y2r_pkg::UbTab[req_ff.chroma_blue];
      ug     = y2r_pkg::UgTab[req_ff.chroma_blue];
      vg     = y2r_pkg::VgTab[req_ff.chroma_red];
      vr     = y2r_pkg::VrTab[req_ff.chroma_red];
      g_term = {{2{ug[6]}}, ug} + {vg[7], vg};
   end

   y2r_pixel u_pix_tl (
      .luma(req_ff.luma_top_left), .blue_term(ub), .green_term(g_term),
      .red_term(vr), .pixel(pix_tl)
   );
   y2r_pixel u_pix_tr (
      .luma(req_ff.luma_top_right), .blue_term(ub), .green_term(g_term),
      .red_term(vr), .pixel(pix_tr)
   );
   y2r_pixel u_pix_bl (
      .luma(req_ff.luma_bottom_left), .blue_term(ub), .green_term(g_term),
      .red_term(vr), .pixel(pix_bl)
   );
   y2r_pixel u_pix_br (
      .luma(req_ff.luma_bottom_right), .blue_term(ub), .green_term(g_term),
      .red_term(vr), .pixel(pix_br)
   );

   always_comb begin
      rsp_valid_in       = stage_valid_ff;
      rsp_in.top_pair    = {pix_tr, pix_tl};
      rsp_in.bottom_pair = {pix_br, pix_bl};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every accepted beat yields a result after the input and result registers
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat produced no result");

   // no result without a matching accepted beat
   a_rsp_has_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching input beat");

   // neutral chroma gives gray: top-left blue and green[5:1] equal red, bottom-right blue equals red
   a_neutral_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.chroma_blue == 8'd128
                          && req_data.chroma_red == 8'd128, 2))
      |-> (rsp_data.top_pair[4:0] == rsp_data.top_pair[15:11]
           && rsp_data.bottom_pair[20:16] == rsp_data.bottom_pair[31:27]
           && rsp_data.top_pair[10:6] == rsp_data.top_pair[15:11]))
      else $error("neutral chroma did not give a gray pixel");

endmodule

`default_nettype wire
